>>> rtl/irdps_pkg.sv
// Package for the IR distance PID servo controller.
// It holds widths, constants, reset values, register indexes and the sequencer state type.
// It has no dependencies.
package irdps_pkg;

    localparam int SamplesPerUpdate = 50;
    localparam int AdcW      = 10;
    localparam int SumW      = 16;
    localparam int CntW      = 7;
    localparam int DistW     = 15;
    localparam int ErrW      = 17;
    localparam int AccW      = 48;
    localparam int GainW     = 32;
    localparam int PeriodW   = 10;
    localparam int AngleW    = 8;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;
    // Wide enough for the full PID sum and every product in it.
    localparam int TotW      = 64;

    localparam logic [DistW-1:0] DistMinQ  = 15'd2560;
    localparam logic [DistW-1:0] DistMaxQ  = 15'd20480;
    localparam logic [DistW-1:0] DistLowQ  = 15'd2304;
    localparam logic [DistW-1:0] DistHighQ = 15'd20736;
    localparam logic [20:0]      LinNumer  = 21'd1398016;
    localparam logic [SumW-1:0]  AvgOffset = 16'd17;

    localparam logic [GainW-1:0]   KpReset     = 32'd98304;
    localparam logic [GainW-1:0]   KiReset     = 32'd13107;
    localparam logic [GainW-1:0]   KdReset     = 32'd203161600;
    localparam logic [DistW-1:0]   SetptReset  = 15'd5120;
    localparam logic [PeriodW-1:0] PeriodReset = 10'd50;
    localparam logic [DistW-1:0]   BandReset   = 15'd768;

    localparam logic [CfgIdxW-1:0] RegKp     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegKi     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKd     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSetpt  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegPeriod = 3'd4;
    localparam logic [CfgIdxW-1:0] RegBand   = 3'd5;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_AVG,
        ST_LIN,
        ST_ERR,
        ST_MULP,
        ST_MULI,
        ST_MULD,
        ST_DIVD,
        ST_SUM,
        ST_MAP,
        ST_OUT
    } state_t;

endpackage

>>> rtl/irdps_serdiv.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on nothing but its parameters.
module irdps_serdiv #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> rtl/irdps_sermul.sv
// Shift-add multiplier: one bit of the unsigned 32-bit multiplier per cycle.
// Signed multiplicand; produces a signed 64-bit product. Depends on nothing.
module irdps_sermul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        gain,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [63:0] product
);
    logic [31:0]        mlt_reg, mlt_next;
    logic signed [63:0] mcd_reg, mcd_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        mlt_next  = mlt_reg;
        mcd_next  = mcd_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mlt_next  = gain;
            mcd_next  = 64'(value);
            acc_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mlt_reg[0])
            begin
                acc_next = acc_reg + mcd_reg;
            end
            mlt_next = {1'b0, mlt_reg[31:1]};
            mcd_next = mcd_reg <<< 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mlt_reg <= mlt_next;
        mcd_reg <= mcd_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

>>> rtl/ir_distance_pid_servo_controller_top.sv
// IR distance PID servo controller, top level.
//
// Usage: raw 10-bit ADC samples enter on the s_axis channel, one per transfer.
// Configuration writes enter on the cfg channel (index 0..5: kp, ki, kd,
// setpoint, update period, integral band); writes to other indexes are ignored.
// Every SAMPLES_PER_UPDATE samples one result leaves on m_axis carrying the
// servo angle and the clamped measured distance.
// A sample that does not close a group is only added to the running sum.
// A closing sample starts a sequence run on one serial divider (used for the
// average, the linearization unless the average is at or below the offset,
// the derivative and the Q.24 shift) and one serial multiplier (used for the
// P, D and, inside the integral band, I products). No sample is taken during it.
// Stall: the result waits in the output register; while it is held the next
// group of samples is still accepted, and the result of that group waits at
// the mapping step until the held transfer completes.
// Reset clears the sums, the PID state and restores default gains.
module ir_distance_pid_servo_controller_top #(
    parameter int SAMPLES_PER_UPDATE = irdps_pkg::SamplesPerUpdate
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] adc_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] servo_angle, [22:8] measured_distance
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int W = irdps_pkg::TotW;

    irdps_pkg::state_t state_reg, state_next;

    logic [31:0] kp_reg, ki_reg, kd_reg;
    logic [14:0] setpt_reg, band_reg;
    logic [9:0]  period_reg;

    logic [15:0] sum_reg;
    logic [6:0]  cnt_reg;
    logic signed [16:0] perr_reg, err_reg;
    logic signed [47:0] iacc_reg;
    logic signed [63:0] p_reg, dprod_reg, d_reg;
    logic [14:0] dist_reg;
    logic [15:0] avg_reg;
    logic [1:0]  sub_reg;       // phase within a state: set once the state's unit has been started
    logic        ovalid_reg;
    logic [7:0]  angle_reg;
    logic [14:0] odist_reg;

    logic div_start, div_done, mul_start, mul_done;
    logic [W-1:0] div_a, div_b, div_q;
    logic [31:0] mul_g;
    logic signed [31:0] mul_v;
    logic signed [63:0] mul_p;

    logic in_acc, last_sample, out_free;
    logic [15:0] sum_add;

    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign sum_add       = sum_reg + {6'd0, s_axis_tdata[9:0]};
    assign last_sample   = (cnt_reg + 7'd1) >= 7'(SAMPLES_PER_UPDATE);
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == irdps_pkg::ST_ACCUM);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, odist_reg, angle_reg};

    irdps_serdiv #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    irdps_sermul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .gain(mul_g),
        .value(mul_v), .done(mul_done), .product(mul_p)
    );

    // Working values for the arithmetic steps.
    logic signed [17:0] emag;
    logic signed [63:0] iprod_ext, inew, total;
    logic [63:0] dmag, tmag;
    logic signed [63:0] tval;
    logic signed [63:0] ang;
    logic [20:0] lin_q;
    logic signed [21:0] lin_d;

    always_comb
    begin
        emag      = err_reg[16] ? -18'(err_reg) : 18'(err_reg);
        iprod_ext = 64'(iacc_reg) + mul_p;
        inew      = iprod_ext;
        if (iprod_ext > 64'sh7FFF_FFFF_FFFF)
        begin
            inew = 64'sh7FFF_FFFF_FFFF;
        end
        if (iprod_ext < -64'sh8000_0000_0000)
        begin
            inew = -64'sh8000_0000_0000;
        end
        dmag  = dprod_reg[63] ? 64'(-dprod_reg) : 64'(dprod_reg);
        total = p_reg + 64'(iacc_reg) + d_reg;
        tmag  = total[63] ? 64'(-total) : 64'(total);
        tval  = total[63] ? -$signed(div_q) : $signed(div_q);
        // The mapping (t+150)*150/300 is half of t+150, truncated toward zero.
        ang   = tval + 64'sd150;
        lin_q = div_q[20:0];
        lin_d = $signed({1'b0, lin_q}) - 22'sd512;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irdps_pkg::ST_ACCUM: if (in_acc && last_sample) state_next = irdps_pkg::ST_AVG;
            irdps_pkg::ST_AVG:   if (div_done) state_next = irdps_pkg::ST_LIN;
            irdps_pkg::ST_LIN:
                if (sub_reg == 2'd0 && avg_reg <= irdps_pkg::AvgOffset)
                    state_next = irdps_pkg::ST_ERR;
                else if (div_done) state_next = irdps_pkg::ST_ERR;
            irdps_pkg::ST_ERR:   state_next = irdps_pkg::ST_MULP;
            irdps_pkg::ST_MULP:  if (mul_done) state_next = irdps_pkg::ST_MULI;
            irdps_pkg::ST_MULI:  if (mul_done || (sub_reg == 2'd0 &&
                                     !(emag < 18'(band_reg)))) state_next = irdps_pkg::ST_MULD;
            irdps_pkg::ST_MULD:  if (mul_done) state_next = irdps_pkg::ST_DIVD;
            irdps_pkg::ST_DIVD:  if (div_done) state_next = irdps_pkg::ST_SUM;
            irdps_pkg::ST_SUM:   if (div_done) state_next = irdps_pkg::ST_MAP;
            irdps_pkg::ST_MAP:   if (out_free) state_next = irdps_pkg::ST_OUT;
            irdps_pkg::ST_OUT:   state_next = irdps_pkg::ST_ACCUM;
            default:             state_next = irdps_pkg::ST_ACCUM;
        endcase
    end

    // Unit start strobes and operands.
    always_comb
    begin
        div_start = 1'b0;
        mul_start = 1'b0;
        div_a = '0;
        div_b = 64'd1;
        mul_g = kp_reg;
        mul_v = 32'(err_reg);
        case (state_reg)
            irdps_pkg::ST_AVG:
            begin
                div_start = (sub_reg == 2'd0);
                div_a = 64'(sum_reg);
                div_b = 64'(SAMPLES_PER_UPDATE);
            end
            irdps_pkg::ST_LIN:
            begin
                div_start = (sub_reg == 2'd0) && (avg_reg > irdps_pkg::AvgOffset);
                div_a = 64'(irdps_pkg::LinNumer);
                div_b = 64'(avg_reg - irdps_pkg::AvgOffset);
            end
            irdps_pkg::ST_MULP:
            begin
                mul_start = (sub_reg == 2'd0);
            end
            irdps_pkg::ST_MULI:
            begin
                mul_start = (sub_reg == 2'd0) && (emag < 18'(band_reg));
                mul_g = ki_reg;
            end
            irdps_pkg::ST_MULD:
            begin
                mul_start = (sub_reg == 2'd0);
                mul_g = kd_reg;
                mul_v = 32'(err_reg) - 32'(perr_reg);
            end
            irdps_pkg::ST_DIVD:
            begin
                div_start = (sub_reg == 2'd0);
                div_a = dmag;
                div_b = (period_reg == '0) ? 64'd1 : 64'(period_reg);
            end
            irdps_pkg::ST_SUM:
            begin
                div_start = (sub_reg == 2'd0);
                div_a = tmag;
                div_b = 64'd16777216;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= irdps_pkg::ST_ACCUM;
            kp_reg     <= irdps_pkg::KpReset;
            ki_reg     <= irdps_pkg::KiReset;
            kd_reg     <= irdps_pkg::KdReset;
            setpt_reg  <= irdps_pkg::SetptReset;
            period_reg <= irdps_pkg::PeriodReset;
            band_reg   <= irdps_pkg::BandReset;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            perr_reg   <= '0;
            iacc_reg   <= '0;
            sub_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                sub_reg <= '0;
            end
            else if (div_start || mul_start)
            begin
                sub_reg <= 2'd1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    irdps_pkg::RegKp:     kp_reg     <= cfg_data;
                    irdps_pkg::RegKi:     ki_reg     <= cfg_data;
                    irdps_pkg::RegKd:     kd_reg     <= cfg_data;
                    irdps_pkg::RegSetpt:  setpt_reg  <= cfg_data[14:0];
                    irdps_pkg::RegPeriod: period_reg <= cfg_data[9:0];
                    irdps_pkg::RegBand:   band_reg   <= cfg_data[14:0];
                    default:              kp_reg     <= kp_reg;
                endcase
            end
            if (in_acc)
            begin
                sum_reg <= sum_add;
                if (last_sample)
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            if (state_reg == irdps_pkg::ST_AVG && div_done)
            begin
                sum_reg <= '0;
            end
            if (state_reg == irdps_pkg::ST_MULI)
            begin
                if (sub_reg == 2'd0 && !(emag < 18'(band_reg)))
                begin
                    iacc_reg <= '0;
                end
                else if (mul_done)
                begin
                    iacc_reg <= inew[47:0];
                end
            end
            if (state_reg == irdps_pkg::ST_MAP)
            begin
                perr_reg <= err_reg;
            end
            if (state_reg == irdps_pkg::ST_MAP && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == irdps_pkg::ST_AVG && div_done)
        begin
            avg_reg <= div_q[15:0];
        end
        if (state_reg == irdps_pkg::ST_LIN)
        begin
            if (sub_reg == 2'd0 && avg_reg < irdps_pkg::AvgOffset)
                dist_reg <= irdps_pkg::DistLowQ;
            else if (sub_reg == 2'd0 && avg_reg == irdps_pkg::AvgOffset)
                dist_reg <= irdps_pkg::DistHighQ;
            else if (div_done)
            begin
                if (lin_d > $signed({7'b0, irdps_pkg::DistMaxQ}))
                    dist_reg <= irdps_pkg::DistHighQ;
                else if (lin_d < $signed({7'b0, irdps_pkg::DistMinQ}))
                    dist_reg <= irdps_pkg::DistLowQ;
                else
                    dist_reg <= lin_d[14:0];
            end
        end
        if (state_reg == irdps_pkg::ST_ERR)
        begin
            err_reg <= $signed({2'b0, setpt_reg}) - $signed({2'b0, dist_reg});
        end
        if (state_reg == irdps_pkg::ST_MULP && mul_done)
        begin
            p_reg <= mul_p;
        end
        if (state_reg == irdps_pkg::ST_MULD && mul_done)
        begin
            dprod_reg <= mul_p;
        end
        if (state_reg == irdps_pkg::ST_DIVD && div_done)
        begin
            d_reg <= dprod_reg[63] ? -$signed(div_q) : $signed(div_q);
        end
        if (state_reg == irdps_pkg::ST_MAP && out_free)
        begin
            if (ang < 64'sd40)
                angle_reg <= 8'd20;
            else if (ang >= 64'sd322)
                angle_reg <= 8'd160;
            else
                angle_reg <= ang[8:1];
            odist_reg <= dist_reg;
        end
    end
endmodule
